// ===== rtl/core/sdcp_pkg.sv =====
package sdcp_pkg;

  localparam int LINE_BYTES_DEF = 16;
  localparam int ID_LEN_DEF     = 29;
  localparam int ID_TEXT_LEN    = 29;

  localparam logic [11:0] RESET_LEVEL_RST = 12'h800;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4e;

  localparam logic [7:0] ID_ROM [0:ID_TEXT_LEN-1] = '{
    8'h53, 8'h45, 8'h52, 8'h49, 8'h41, 8'h4c, 8'h20, 8'h51,
    8'h55, 8'h41, 8'h44, 8'h20, 8'h44, 8'h41, 8'h43, 8'h20,
    8'h31, 8'h32, 8'h2d, 8'h42, 8'h49, 8'h54, 8'h20, 8'h52,
    8'h45, 8'h56, 8'h2e, 8'h20, 8'h33
  };

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        dac_valid;
    logic [2:0]  dac_channel;
    logic [11:0] dac_value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] id_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'(ID_TEXT_LEN)) begin
      c = ID_ROM[idx[4:0]];
    end else begin
      c = CH_DOT;
    end
    return c;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/serial_dac_command_parser_top.sv =====
// Serial command parser for a four-channel 12-bit DAC.
// s_tdata carries one received ASCII byte per transaction. CR is ignored;
// other bytes are stored in a line memory (LINE_BYTES-1 deep, extra bytes
// dropped) until LF closes a non-empty line. The line is then decoded:
// "*IDN?" returns the identity text and LF, "*RST" writes reset_level to
// all four channels and echoes "*RST" LF, "<1-4> <hex>" writes one channel
// and echoes the line and LF, anything else returns "ERR" LF.
// m_tuser flags a reply byte (bit 0) or a DAC write (bit 1); m_tlast marks
// the final result of a line.
// Sequence: after LF the parser reads back up to six stored bytes through
// the memory's registered read port, decodes them, then emits one result
// per cycle while m_tready is high: up to ID_LEN+1 results, 9 for "*RST".
// s_tready is low during this time.
// The output register holds its result while m_tready is low and emission
// pauses; a new byte may be taken while the last result still waits.
// Reset clears the line, drops any pending result and sets reset_level to
// 0x800. cfg_wr_en/cfg_wr_data write reset_level.
module serial_dac_command_parser_top #(
  parameter int LINE_BYTES = sdcp_pkg::LINE_BYTES_DEF,
  parameter int ID_LEN     = sdcp_pkg::ID_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] tx_byte, [10:8] dac_channel, [22:11] dac_value
  output logic [1:0]  m_tuser,   // [0] tx_valid, [1] dac_valid
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int AW    = $clog2(DEPTH);

  logic [11:0]       reset_level;
  sdcp_pkg::result_t res;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [7:0]        mem_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_level <= sdcp_pkg::RESET_LEVEL_RST;
    end else if (cfg_wr_en) begin
      reset_level <= cfg_wr_data;
    end
  end

  sdcp_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sdcp_parser #(
    .LINE_BYTES (LINE_BYTES),
    .ID_LEN     (ID_LEN),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_data     (s_tdata),
    .in_ready    (s_tready),
    .reset_level (reset_level),
    .res_valid   (m_tvalid),
    .res         (res),
    .res_ready   (m_tready),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  assign m_tdata = {1'b0, res.dac_value, res.dac_channel, res.tx_byte};
  assign m_tuser = {res.dac_valid, res.tx_valid};
  assign m_tlast = res.last;

endmodule

// ===== rtl/core/sdcp_line_mem.sv =====
module sdcp_line_mem #(
  parameter int DEPTH = sdcp_pkg::LINE_BYTES_DEF - 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/sdcp_parser.sv =====
module sdcp_parser #(
  parameter int LINE_BYTES = sdcp_pkg::LINE_BYTES_DEF,
  parameter int ID_LEN     = sdcp_pkg::ID_LEN_DEF,
  parameter int DEPTH      = LINE_BYTES - 1,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_data,
  output logic                in_ready,
  input  logic [11:0]         reset_level,
  output logic                res_valid,
  output sdcp_pkg::result_t   res,
  input  logic                res_ready,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic [7:0]          mem_wr_data,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic [7:0]          mem_rd_data
);

  localparam int FW = $clog2(LINE_BYTES);
  localparam int CW = $clog2(ID_LEN + 10);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLASS = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [1:0] K_IDN = 2'd0;
  localparam logic [1:0] K_RST = 2'd1;
  localparam logic [1:0] K_SET = 2'd2;
  localparam logic [1:0] K_ERR = 2'd3;

  localparam logic [2:0] SCAN_LAST = 3'd5;

  logic [1:0]    state;
  logic [FW-1:0] fill;
  logic [2:0]    scan_idx;
  logic [2:0]    len;
  logic [7:0]    b [0:4];
  logic [1:0]    kind;
  logic [2:0]    dac_ch;
  logic [11:0]   dac_val;
  logic [CW-1:0] cnt;

  logic                in_accept;
  logic                is_cr;
  logic                is_lf;
  logic                scan_end;
  logic [1:0]          kind_next;
  logic [11:0]         hex_next;
  logic                hex_ok;
  sdcp_pkg::hex_t      hd;
  logic [2:0]          echo_idx;
  sdcp_pkg::result_t   emit_res;
  logic                load;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign is_cr     = (in_data == sdcp_pkg::CH_CR);
  assign is_lf     = (in_data == sdcp_pkg::CH_LF);

  assign mem_wr_en   = in_accept && !is_cr && !is_lf && (fill < FW'(DEPTH));
  assign mem_wr_addr = fill[AW-1:0];
  assign mem_wr_data = in_data;
  assign mem_rd_addr = (state == ST_SCAN) ? AW'(scan_idx + 3'd1) : '0;

  assign scan_end = (FW'(scan_idx) >= fill) || (mem_rd_data == 8'h00);

  always_comb begin
    hex_ok   = 1'b1;
    hex_next = 12'd0;
    for (int i = 2; i < 5; i++) begin
      hd = sdcp_pkg::hex_digit(b[i]);
      if (3'(i) < len) begin
        if (!hd.ok) begin
          hex_ok = 1'b0;
        end
        hex_next = {hex_next[7:0], hd.val};
      end
    end
    if (len == 3'd5 && b[0] == sdcp_pkg::CH_STAR && b[1] == sdcp_pkg::CH_I &&
        b[2] == sdcp_pkg::CH_D && b[3] == sdcp_pkg::CH_N &&
        b[4] == sdcp_pkg::CH_QUERY) begin
      kind_next = K_IDN;
    end else if (len == 3'd4 && b[0] == sdcp_pkg::CH_STAR &&
                 b[1] == sdcp_pkg::CH_R && b[2] == sdcp_pkg::CH_S &&
                 b[3] == sdcp_pkg::CH_T) begin
      kind_next = K_RST;
    end else if (len >= 3'd3 && len <= 3'd5 && b[0] >= sdcp_pkg::CH_ONE &&
                 b[0] <= sdcp_pkg::CH_FOUR && b[1] == sdcp_pkg::CH_SPACE &&
                 hex_ok) begin
      kind_next = K_SET;
    end else begin
      kind_next = K_ERR;
    end
  end

  always_comb begin
    emit_res = '0;
    echo_idx = (kind == K_RST) ? 3'(cnt - CW'(4)) : 3'(cnt - CW'(1));
    unique case (kind)
      K_IDN: begin
        emit_res.tx_valid = 1'b1;
        if (cnt == CW'(ID_LEN)) begin
          emit_res.tx_byte = sdcp_pkg::CH_LF;
          emit_res.last    = 1'b1;
        end else begin
          emit_res.tx_byte = sdcp_pkg::id_char(6'(cnt));
        end
      end
      K_RST: begin
        if (cnt < CW'(4)) begin
          emit_res.dac_valid   = 1'b1;
          emit_res.dac_channel = 3'(cnt + CW'(1));
          emit_res.dac_value   = reset_level;
        end else if (cnt < CW'(8)) begin
          emit_res.tx_valid = 1'b1;
          emit_res.tx_byte  = b[echo_idx];
        end else begin
          emit_res.tx_valid = 1'b1;
          emit_res.tx_byte  = sdcp_pkg::CH_LF;
          emit_res.last     = 1'b1;
        end
      end
      K_SET: begin
        if (cnt == '0) begin
          emit_res.dac_valid   = 1'b1;
          emit_res.dac_channel = dac_ch;
          emit_res.dac_value   = dac_val;
        end else if (cnt <= CW'(len)) begin
          emit_res.tx_valid = 1'b1;
          emit_res.tx_byte  = b[echo_idx];
        end else begin
          emit_res.tx_valid = 1'b1;
          emit_res.tx_byte  = sdcp_pkg::CH_LF;
          emit_res.last     = 1'b1;
        end
      end
      K_ERR: begin
        emit_res.tx_valid = 1'b1;
        if (cnt == CW'(0)) begin
          emit_res.tx_byte = sdcp_pkg::CH_E;
        end else if (cnt < CW'(3)) begin
          emit_res.tx_byte = sdcp_pkg::CH_R;
        end else begin
          emit_res.tx_byte = sdcp_pkg::CH_LF;
          emit_res.last    = 1'b1;
        end
      end
      default: emit_res = '0;
    endcase
  end

  assign load = (state == ST_EMIT) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (is_lf) begin
              if (fill != '0) begin
                state <= ST_SCAN;
              end
            end else if (mem_wr_en) begin
              fill <= fill + FW'(1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_end || scan_idx == SCAN_LAST) begin
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          state <= ST_EMIT;
          fill  <= '0;
        end
        ST_EMIT: begin
          if (load && emit_res.last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= emit_res;
      cnt <= cnt + CW'(1);
    end
    unique case (state)
      ST_IDLE: begin
        scan_idx <= '0;
      end
      ST_SCAN: begin
        if (scan_end) begin
          len <= scan_idx;
        end else begin
          if (scan_idx != SCAN_LAST) begin
            b[scan_idx] <= mem_rd_data;
          end else begin
            len <= 3'd6;
          end
          scan_idx <= scan_idx + 3'd1;
        end
      end
      ST_CLASS: begin
        kind    <= kind_next;
        dac_ch  <= 3'(b[0] - 8'h30);
        dac_val <= hex_next;
        cnt     <= '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sdcp_checker.sv =====
module sdcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
      $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled transaction changed");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser))
    else $error("result is neither a reply byte nor a DAC write");

  a_dac_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tlast && m_tdata[10:8] != 3'd0 &&
      m_tdata[10:8] <= 3'd4)
    else $error("bad DAC write");

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0] && m_tdata[7:0] == 8'h0a)
    else $error("reply does not end in LF");

endmodule

bind serial_dac_command_parser_top sdcp_checker u_chk (.*);
